@@ rtl/indexed_min_heap_unit_macros.svh @@
// Assertion macros shared by the heap unit RTL.
`ifndef INDEXED_MIN_HEAP_UNIT_MACROS_SVH
`define INDEXED_MIN_HEAP_UNIT_MACROS_SVH
// Consequent checked in the same cycle as the antecedent.
`define IMH_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Consequent checked in the cycle after the antecedent.
`define IMH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ rtl/imh_pkg.sv @@
// Types, constants and codes of the indexed min-heap unit.
package imh_pkg;
   localparam int CAPACITY   = 1024;
   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int CNT_BITS   = IDX_BITS + 1;
   localparam int SCORE_BITS = 32;
   localparam int TAG_BITS   = 16;

   typedef enum logic [1:0] {
      MODE_INSERT  = 2'd0,
      MODE_REMOVE  = 2'd1,
      MODE_RESCORE = 2'd2,
      MODE_POP     = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_DONE   = 3'd0,
      ST_POPPED = 3'd1,
      ST_KEPT   = 3'd2,
      ST_EMPTY  = 3'd3,
      ST_FULL   = 3'd4,
      ST_BADPOS = 3'd5
   } status_type;

   localparam logic KIND_NOTICE = 1'b0;
   localparam logic KIND_FINAL  = 1'b1;

   typedef struct packed {
      mode_type              mode;
      logic [IDX_BITS-1:0]   position;
      logic [SCORE_BITS-1:0] score;
      logic [TAG_BITS-1:0]   tag;
      logic [SCORE_BITS-1:0] threshold;
   } req_type;

   typedef struct packed {
      logic                  kind;
      logic [TAG_BITS-1:0]   entry_tag;
      logic [IDX_BITS-1:0]   entry_position;
      logic [SCORE_BITS-1:0] entry_score;
      logic                  reached_root;
      status_type            status;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic [SCORE_BITS-1:0] score;
      logic [TAG_BITS-1:0]   tag;
   } entry_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_LOAD,
      DP_INSERT,
      DP_READ_POS,
      DP_RESCORE_WR,
      DP_READ_ROOT,
      DP_POP_CAP,
      DP_REMOVE_RD,
      DP_REMOVE_WR,
      DP_UP_RD,
      DP_UP_STOP,
      DP_UP_SWAP1,
      DP_UP_SWAP2,
      DP_DN_RDL,
      DP_DN_RDR,
      DP_DN_SWAP1,
      DP_DN_SWAP2,
      DP_FINAL
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      status_type status;
      logic       show_pop;
   } dp_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     full;
      logic     bad;
      logic     empty;
      logic     last_hit;
      logic     i_zero;
      logic     l_valid;
      logic     dn_stop;
      logic     up_stop;
      logic     below;
      logic     pop_below;
   } dp_stat_type;
endpackage

@@ rtl/indexed_min_heap_unit.sv @@
// Top level of the indexed binary min-heap unit.
// Usage:
//   A transaction is taken when start is high and busy is low; req_item
//   carries mode, position, score, tag and threshold.
//   Results leave on rsp_item, each valid for one cycle under rsp_strobe.
//   Move notices (kind 0) come first, one per heap slot that got a new
//   entry; the final result (kind 1, last 1) closes the transaction.
//   Rejected transactions (full, empty, bad position) register their final
//   result straight from the check step. A sift walks a level down as read
//   left child, read right child, compare with first write, second write,
//   and a level up as read parent, compare with first write, second write,
//   after setup (check, slot or tail read, slot write) and before the final
//   step. These steps per level are set by the single read and single write
//   port of the heap memory.
//   One transaction at a time; busy stays high until the final result is
//   registered, and a new start may be taken in the cycle it is shown.
//   Reset empties the heap (entry count to zero); memory contents are not
//   cleared, since slots at or above the count are never used.
//   The receiver cannot stall: every result must be taken when strobed.
`include "indexed_min_heap_unit_macros.svh"
module indexed_min_heap_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  imh_pkg::req_type  req_item,
   output logic              rsp_strobe,
   output imh_pkg::rsp_type  rsp_item
);
   imh_pkg::dp_cmd_type  cmd;
   imh_pkg::dp_stat_type stat;

   // sequencer: one step of the current transaction per cycle
   imh_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // heap memory, sift registers, result register
   imh_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   `IMH_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction not busy")
   `IMH_ASSERT_SAME(a_final_idle, rsp_strobe && rsp_item.last, !busy, "final while busy")
   `IMH_ASSERT_SAME(a_notice_busy, rsp_strobe && !rsp_item.last, busy, "notice while idle")
endmodule

@@ rtl/imh_ctrl.sv @@
// Sequencer of the heap unit: walks each transaction through its steps.
module imh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  imh_pkg::dp_stat_type stat,
   output imh_pkg::dp_cmd_type  cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_RS_WR, S_POP_CHK, S_REM_RD, S_REM_WR,
      S_DN_RL, S_DN_RR, S_DN_CMP, S_DN_SW2,
      S_UP_RD, S_UP_CMP, S_UP_SW2, S_FIN
   } state_type;

   state_type state_ff, state_in;
   imh_pkg::status_type done_status;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      if (stat.mode != imh_pkg::MODE_POP) begin
         done_status = imh_pkg::ST_DONE;
      end else if (stat.pop_below) begin
         done_status = imh_pkg::ST_POPPED;
      end else begin
         done_status = imh_pkg::ST_KEPT;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = imh_pkg::DP_NOP;
      cmd.status   = imh_pkg::ST_DONE;
      cmd.show_pop = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = imh_pkg::DP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            unique case (stat.mode)
               imh_pkg::MODE_INSERT: begin
                  if (stat.full) begin
                     cmd.op = imh_pkg::DP_FINAL; cmd.status = imh_pkg::ST_FULL;
                     state_in = S_IDLE;
                  end else begin
                     cmd.op = imh_pkg::DP_INSERT; state_in = S_UP_RD;
                  end
               end
               imh_pkg::MODE_REMOVE: begin
                  if (stat.bad) begin
                     cmd.op = imh_pkg::DP_FINAL; cmd.status = imh_pkg::ST_BADPOS;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_REM_RD;
                  end
               end
               imh_pkg::MODE_RESCORE: begin
                  if (stat.bad) begin
                     cmd.op = imh_pkg::DP_FINAL; cmd.status = imh_pkg::ST_BADPOS;
                     state_in = S_IDLE;
                  end else begin
                     cmd.op = imh_pkg::DP_READ_POS; state_in = S_RS_WR;
                  end
               end
               imh_pkg::MODE_POP: begin
                  if (stat.empty) begin
                     cmd.op = imh_pkg::DP_FINAL; cmd.status = imh_pkg::ST_EMPTY;
                     state_in = S_IDLE;
                  end else begin
                     cmd.op = imh_pkg::DP_READ_ROOT; state_in = S_POP_CHK;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_RS_WR: begin
            cmd.op = imh_pkg::DP_RESCORE_WR; state_in = S_DN_RL;
         end
         S_POP_CHK: begin
            cmd.op   = imh_pkg::DP_POP_CAP;
            state_in = stat.below ? S_REM_RD : S_FIN;
         end
         S_REM_RD: begin
            cmd.op   = imh_pkg::DP_REMOVE_RD;
            state_in = stat.last_hit ? S_FIN : S_REM_WR;
         end
         S_REM_WR: begin
            cmd.op = imh_pkg::DP_REMOVE_WR; state_in = S_DN_RL;
         end
         S_DN_RL: begin
            if (stat.l_valid) begin
               cmd.op = imh_pkg::DP_DN_RDL; state_in = S_DN_RR;
            end else begin
               state_in = S_UP_RD;
            end
         end
         S_DN_RR: begin
            cmd.op = imh_pkg::DP_DN_RDR; state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (stat.dn_stop) begin
               state_in = S_UP_RD;
            end else begin
               cmd.op = imh_pkg::DP_DN_SWAP1; state_in = S_DN_SW2;
            end
         end
         S_DN_SW2: begin
            cmd.op = imh_pkg::DP_DN_SWAP2; state_in = S_DN_RL;
         end
         S_UP_RD: begin
            if (stat.i_zero) begin
               state_in = S_FIN;
            end else begin
               cmd.op = imh_pkg::DP_UP_RD; state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (stat.up_stop) begin
               cmd.op = imh_pkg::DP_UP_STOP; state_in = S_FIN;
            end else begin
               cmd.op = imh_pkg::DP_UP_SWAP1; state_in = S_UP_SW2;
            end
         end
         S_UP_SW2: begin
            cmd.op = imh_pkg::DP_UP_SWAP2; state_in = S_UP_RD;
         end
         S_FIN: begin
            cmd.op       = imh_pkg::DP_FINAL;
            cmd.status   = done_status;
            cmd.show_pop = (stat.mode == imh_pkg::MODE_POP);
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

@@ rtl/imh_datapath.sv @@
// Heap storage, working registers and result register of the heap unit.
module imh_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  imh_pkg::req_type     req_item,
   input  imh_pkg::dp_cmd_type  cmd,
   output imh_pkg::dp_stat_type stat,
   output logic                 rsp_strobe,
   output imh_pkg::rsp_type     rsp_item
);
   localparam int IB = imh_pkg::IDX_BITS;
   localparam int CB = imh_pkg::CNT_BITS;

   imh_pkg::entry_type heap_ff [imh_pkg::CAPACITY];
   imh_pkg::entry_type rdata_ff, cur_ff, cur_in, other_ff, other_in, pop_ff, pop_in;
   imh_pkg::req_type   req_ff, req_in;
   logic [CB-1:0]      count_ff, count_in;
   logic [IB-1:0]      idx_ff, idx_in, par_ff, par_in, min_ff, min_in, pos_ff, pos_in;
   logic               flag_ff, flag_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   imh_pkg::rsp_type   rsp_ff, rsp_in;

   logic               we;
   logic [IB-1:0]      waddr, raddr;
   imh_pkg::entry_type wdata, best;
   logic [CB-1:0]      lidx, count_m1;
   logic [CB:0]        ridx;
   logic [IB-1:0]      parent, mpos;
   logic               r_valid, took;

   assign lidx     = {idx_ff, 1'b1};
   assign ridx     = {({1'b0, idx_ff} + CB'(1)), 1'b0};
   assign count_m1 = count_ff - CB'(1);
   assign parent   = IB'((idx_ff - IB'(1)) >> 1);
   assign r_valid  = (ridx < {1'b0, count_ff});

   // smallest of current entry and its children
   always_comb begin
      best = cur_ff;
      mpos = idx_ff;
      took = 1'b0;
      if (other_ff.score < cur_ff.score) begin
         best = other_ff; mpos = lidx[IB-1:0]; took = 1'b1;
      end
      if (r_valid && (rdata_ff.score < best.score)) begin
         best = rdata_ff; mpos = ridx[IB-1:0]; took = 1'b1;
      end
   end

   always_comb begin
      stat.mode      = req_ff.mode;
      stat.full      = (count_ff == CB'(imh_pkg::CAPACITY));
      stat.bad       = ({1'b0, req_ff.position} >= count_ff);
      stat.empty     = (count_ff == '0);
      stat.last_hit  = ({1'b0, pos_ff} == count_m1);
      stat.i_zero    = (idx_ff == '0);
      stat.l_valid   = (lidx < count_ff);
      stat.dn_stop   = !took;
      stat.up_stop   = (rdata_ff.score <= cur_ff.score);
      stat.below     = (rdata_ff.score < req_ff.threshold);
      stat.pop_below = (pop_ff.score < req_ff.threshold);
   end

   always_comb begin
      req_in        = req_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      other_in      = other_ff;
      pop_in        = pop_ff;
      idx_in        = idx_ff;
      par_in        = par_ff;
      min_in        = min_ff;
      pos_in        = pos_ff;
      flag_in       = flag_ff;
      we            = 1'b0;
      waddr         = '0;
      wdata         = cur_ff;
      raddr         = '0;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      rsp_in.kind   = imh_pkg::KIND_NOTICE;
      rsp_in.status = imh_pkg::ST_DONE;
      unique case (cmd.op)
         imh_pkg::DP_NOP: ;
         imh_pkg::DP_LOAD: begin
            req_in  = req_item;
            pos_in  = req_item.position;
            flag_in = 1'b0;
         end
         imh_pkg::DP_INSERT: begin
            wdata    = '{score: req_ff.score, tag: req_ff.tag};
            we       = 1'b1;
            waddr    = count_ff[IB-1:0];
            cur_in   = wdata;
            idx_in   = count_ff[IB-1:0];
            count_in = count_ff + CB'(1);
         end
         imh_pkg::DP_READ_POS: raddr = pos_ff;
         imh_pkg::DP_RESCORE_WR: begin
            wdata  = '{score: req_ff.score, tag: rdata_ff.tag};
            we     = 1'b1;
            waddr  = pos_ff;
            cur_in = wdata;
            idx_in = pos_ff;
         end
         imh_pkg::DP_READ_ROOT: begin
            raddr  = '0;
            pos_in = '0;
         end
         imh_pkg::DP_POP_CAP: pop_in = rdata_ff;
         imh_pkg::DP_REMOVE_RD: begin
            count_in = count_m1;
            raddr    = count_m1[IB-1:0];
         end
         imh_pkg::DP_REMOVE_WR: begin
            wdata  = rdata_ff;
            we     = 1'b1;
            waddr  = pos_ff;
            cur_in = rdata_ff;
            idx_in = pos_ff;
         end
         imh_pkg::DP_UP_RD: begin
            raddr  = parent;
            par_in = parent;
         end
         imh_pkg::DP_UP_STOP: flag_in = 1'b0;
         imh_pkg::DP_UP_SWAP1: begin
            wdata    = cur_ff;
            we       = 1'b1;
            waddr    = par_ff;
            other_in = rdata_ff;
         end
         imh_pkg::DP_UP_SWAP2: begin
            wdata   = other_ff;
            we      = 1'b1;
            waddr   = idx_ff;
            idx_in  = par_ff;
            flag_in = 1'b1;
         end
         imh_pkg::DP_DN_RDL: raddr = lidx[IB-1:0];
         imh_pkg::DP_DN_RDR: begin
            other_in = rdata_ff;
            raddr    = ridx[IB-1:0];
         end
         imh_pkg::DP_DN_SWAP1: begin
            wdata  = best;
            we     = 1'b1;
            waddr  = idx_ff;
            min_in = mpos;
         end
         imh_pkg::DP_DN_SWAP2: begin
            wdata  = cur_ff;
            we     = 1'b1;
            waddr  = min_ff;
            idx_in = min_ff;
         end
         imh_pkg::DP_FINAL: begin
            rsp_strobe_in       = 1'b1;
            rsp_in.kind         = imh_pkg::KIND_FINAL;
            rsp_in.entry_tag    = cmd.show_pop ? pop_ff.tag : '0;
            rsp_in.entry_score  = cmd.show_pop ? pop_ff.score : '0;
            rsp_in.reached_root = flag_ff;
            rsp_in.status       = cmd.status;
            rsp_in.last         = 1'b1;
         end
         default: ;
      endcase
      // every slot write but the rescore write announces the entry now sitting there
      if (we) begin
         rsp_strobe_in         = 1'b1;
         rsp_in.entry_tag      = wdata.tag;
         rsp_in.entry_position = waddr;
      end
      if (cmd.op == imh_pkg::DP_RESCORE_WR) begin
         rsp_strobe_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         heap_ff[waddr] <= wdata;
      end
      rdata_ff <= heap_ff[raddr];
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      cur_ff   <= cur_in;
      other_ff <= other_in;
      pop_ff   <= pop_in;
      idx_ff   <= idx_in;
      par_ff   <= par_in;
      min_ff   <= min_in;
      pos_ff   <= pos_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         count_ff      <= '0;
         flag_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         flag_ff       <= flag_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;
endmodule
